### hw/rtl/hdms_pkg.sv
// shared types, constants and command codes for the hard-disc metropolis sweep unit
// no dependencies; imported by every module of the block
package hdms_pkg;

    // storage and number format
    localparam int MAX_DISCS = 512;
    localparam int FRAC_BITS = 16;
    localparam int ADDR_W    = $clog2(MAX_DISCS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int COORD_W   = 24;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int DISC_W    = 9;
    localparam int ACC_W     = 11;
    localparam int TOT_W     = 2 * ADDR_W;

    // configuration registers
    localparam int LEN_W     = 22;
    localparam int STEP_W    = 19;
    localparam int ACT_W     = 10;
    localparam int CFG_W     = 22;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_DISCS = 2'd2;
    localparam logic [LEN_W-1:0]  BOX_LENGTH_RST   = 22'd3673287;
    localparam logic [STEP_W-1:0] STEP_SIZE_RST    = 19'd65536;
    localparam logic [ACT_W-1:0]  ACTIVE_DISCS_RST = 10'd400;

    // commands
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_SWEEP   = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    // pair pipeline tags
    localparam logic [1:0] TAG_TOTAL = 2'd0;
    localparam logic [1:0] TAG_OLD   = 2'd1;
    localparam logic [1:0] TAG_NEW   = 2'd2;
    localparam logic [1:0] TAG_WRAP  = 2'd3;

    // response selection
    localparam logic [1:0] RSP_ZERO  = 2'd0;
    localparam logic [1:0] RSP_COORD = 2'd1;
    localparam logic [1:0] RSP_SWEEP = 2'd2;

    // random number generator
    localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
    localparam logic [63:0] LCG_ADD = 64'd1442695040888963407;
    localparam logic [63:0] LCG_RST = 64'd1;

    typedef struct packed {
        logic [1:0]                cmd;
        logic [DISC_W-1:0]         disc;
        logic                      axis;
        logic signed [COORD_W-1:0] coord_in;
    } req_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_out;
        logic [ACC_W-1:0]          accepted_moves;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic              take_req;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic              clr_we;
        logic              wr_coord;
        logic              latch_a;
        logic              issue;
        logic [1:0]        tag;
        logic              axis;
        logic              draw;
        logic              mul_disp;
        logic              calc_prop;
        logic              take_u2;
        logic              clr_cnt;
        logic              decide;
        logic              clr_sweep;
        logic              load_rsp;
        logic [1:0]        rsp_sel;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic              busy;
        logic [1:0]        cmd;
        logic [DISC_W-1:0] disc;
    } dp_stat_t;

endpackage

### hw/rtl/hdms_pair_pipe.sv
// pair pipeline: minimum-image distance test and coordinate rewrap, one pair per cycle
// restoring remainder stages against the box length; uses hdms_pkg
module hdms_pair_pipe (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [1:0]                        in_tag,
    input  logic [hdms_pkg::ADDR_W-1:0]       in_addr,
    input  logic signed [hdms_pkg::COORD_W-1:0] ax,
    input  logic signed [hdms_pkg::COORD_W-1:0] ay,
    input  logic signed [hdms_pkg::COORD_W-1:0] bx,
    input  logic signed [hdms_pkg::COORD_W-1:0] by,
    input  logic [hdms_pkg::LEN_W-1:0]        box_len,
    output logic                              out_valid,
    output logic [1:0]                        out_tag,
    output logic [hdms_pkg::ADDR_W-1:0]       out_addr,
    output logic                              out_close,
    output logic signed [hdms_pkg::COORD_W-1:0] out_wrap_x,
    output logic signed [hdms_pkg::COORD_W-1:0] out_wrap_y,
    output logic                              busy
);
    import hdms_pkg::*;

    localparam int REM_ST = DIFF_W;
    localparam int PIPE_N = REM_ST + 4;
    localparam int EXT_W  = LEN_W + REM_ST;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam logic [SQ_W:0] THR = (SQ_W + 1)'(1) << (2 * FRAC_BITS);

    // control shift line
    logic [PIPE_N-1:0]  v_reg;
    logic [1:0]         tag_reg  [PIPE_N];
    logic [ADDR_W-1:0]  addr_reg [PIPE_N];

    // remainder line
    logic [DIFF_W-1:0]        rx_reg   [REM_ST+1];
    logic [DIFF_W-1:0]        ry_reg   [REM_ST+1];
    logic                     negx_reg [REM_ST+1];
    logic                     negy_reg [REM_ST+1];
    logic signed [DIFF_W-1:0] rawx_reg [REM_ST+1];
    logic signed [DIFF_W-1:0] rawy_reg [REM_ST+1];

    logic signed [DIFF_W-1:0]  dfx, dfy;
    logic signed [DIFF_W-1:0]  mix_reg, miy_reg;
    logic signed [COORD_W-1:0] wx1_reg, wy1_reg, wx2_reg, wy2_reg, wx3_reg, wy3_reg;
    logic signed [SQ_W-1:0]    sqx_reg, sqy_reg;
    logic                      close_reg;

    // nonnegative remainder from magnitude and sign
    function automatic logic [LEN_W-1:0] fix_mod(input logic [DIFF_W-1:0] r,
                                                 input logic neg,
                                                 input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] m;
        begin
            m = r[LEN_W-1:0];
            if (neg && (r != '0))
                m = len - r[LEN_W-1:0];
            return m;
        end
    endfunction

    // minimum image in (-L/2, L/2]
    function automatic logic signed [DIFF_W-1:0] min_img(input logic [DIFF_W-1:0] r,
                                                         input logic neg,
                                                         input logic signed [DIFF_W-1:0] raw,
                                                         input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] m;
        logic signed [DIFF_W-1:0] res;
        begin
            m = fix_mod(r, neg, len);
            if (len == '0)
                res = raw;
            else if ({m, 1'b0} > {1'b0, len})
                res = $signed(DIFF_W'(m)) - $signed(DIFF_W'(len));
            else
                res = $signed(DIFF_W'(m));
            return res;
        end
    endfunction

    // rewrap into (0, L]
    function automatic logic signed [COORD_W-1:0] wrap_val(input logic [DIFF_W-1:0] r,
                                                           input logic neg,
                                                           input logic signed [DIFF_W-1:0] raw,
                                                           input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] m;
        logic signed [COORD_W-1:0] res;
        begin
            m = fix_mod(r, neg, len);
            if (len == '0)
                res = raw[COORD_W-1:0];
            else if (m == '0)
                res = $signed(COORD_W'(len));
            else
                res = $signed(COORD_W'(m));
            return res;
        end
    endfunction

    // control line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[PIPE_N-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0]  <= in_tag;
        addr_reg[0] <= in_addr;
        for (int k = 1; k < PIPE_N; k++)
        begin
            tag_reg[k]  <= tag_reg[k-1];
            addr_reg[k] <= addr_reg[k-1];
        end
    end

    // difference, sign and magnitude
    assign dfx = DIFF_W'(bx) - DIFF_W'(ax);
    assign dfy = DIFF_W'(by) - DIFF_W'(ay);

    always_ff @(posedge clk)
    begin
        rawx_reg[0] <= dfx;
        rawy_reg[0] <= dfy;
        negx_reg[0] <= dfx[DIFF_W-1];
        negy_reg[0] <= dfy[DIFF_W-1];
        rx_reg[0]   <= dfx[DIFF_W-1] ? DIFF_W'(-dfx) : DIFF_W'(dfx);
        ry_reg[0]   <= dfy[DIFF_W-1] ? DIFF_W'(-dfy) : DIFF_W'(dfy);
    end

    // one quotient bit per stage
    for (genvar g = 0; g < REM_ST; g++)
    begin : g_rem
        localparam int SH = REM_ST - 1 - g;
        logic [EXT_W-1:0] lsh;
        assign lsh = EXT_W'(box_len) << SH;

        always_ff @(posedge clk)
        begin
            if (EXT_W'(rx_reg[g]) >= lsh)
                rx_reg[g+1] <= rx_reg[g] - lsh[DIFF_W-1:0];
            else
                rx_reg[g+1] <= rx_reg[g];
            if (EXT_W'(ry_reg[g]) >= lsh)
                ry_reg[g+1] <= ry_reg[g] - lsh[DIFF_W-1:0];
            else
                ry_reg[g+1] <= ry_reg[g];
            negx_reg[g+1] <= negx_reg[g];
            negy_reg[g+1] <= negy_reg[g];
            rawx_reg[g+1] <= rawx_reg[g];
            rawy_reg[g+1] <= rawy_reg[g];
        end
    end

    // fold-up, square and compare
    always_ff @(posedge clk)
    begin
        mix_reg <= min_img(rx_reg[REM_ST], negx_reg[REM_ST], rawx_reg[REM_ST], box_len);
        miy_reg <= min_img(ry_reg[REM_ST], negy_reg[REM_ST], rawy_reg[REM_ST], box_len);
        wx1_reg <= wrap_val(rx_reg[REM_ST], negx_reg[REM_ST], rawx_reg[REM_ST], box_len);
        wy1_reg <= wrap_val(ry_reg[REM_ST], negy_reg[REM_ST], rawy_reg[REM_ST], box_len);
        sqx_reg   <= mix_reg * mix_reg;
        sqy_reg   <= miy_reg * miy_reg;
        wx2_reg   <= wx1_reg;
        wy2_reg   <= wy1_reg;
        close_reg <= ((SQ_W + 1)'($unsigned(sqx_reg)) + (SQ_W + 1)'($unsigned(sqy_reg))) < THR;
        wx3_reg   <= wx2_reg;
        wy3_reg   <= wy2_reg;
    end

    assign out_valid  = v_reg[PIPE_N-1];
    assign out_tag    = tag_reg[PIPE_N-1];
    assign out_addr   = addr_reg[PIPE_N-1];
    assign out_close  = close_reg;
    assign out_wrap_x = wx3_reg;
    assign out_wrap_y = wy3_reg;
    assign busy       = |v_reg;

endmodule

### hw/rtl/hdms_dpath.sv
// datapath: position memories, random draws, proposal, overlap counters and response
// instantiates hdms_pair_pipe; uses hdms_pkg
module hdms_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hdms_pkg::req_t                req,
    input  logic [hdms_pkg::LEN_W-1:0]    box_length,
    input  logic [hdms_pkg::STEP_W-1:0]   step_size,
    input  hdms_pkg::dp_cmd_t             cmd,
    output hdms_pkg::dp_stat_t            stat,
    output hdms_pkg::rsp_t                rsp
);
    import hdms_pkg::*;

    // position memories, one per axis
    logic [COORD_W-1:0] mem_x [MAX_DISCS];
    logic [COORD_W-1:0] mem_y [MAX_DISCS];
    logic signed [COORD_W-1:0] rd_x_reg, rd_y_reg;

    logic                      we_x, we_y;
    logic [ADDR_W-1:0]         waddr;
    logic [COORD_W-1:0]        wdat_x, wdat_y;

    req_t                      req_reg;
    logic                      disc_ok;
    logic signed [COORD_W-1:0] a_x_reg, a_y_reg;

    // random generator
    logic [63:0]               lcg_reg;
    logic [63:0]               p_ll_reg;
    logic [31:0]               p_hl_reg, p_lh_reg;
    logic                      pend_reg;
    logic                      u2_ok_reg;

    // proposal
    logic [STEP_W+31:0]        prod_reg;
    logic signed [COORD_W-1:0] prop_reg;
    logic                      prop_axis_reg;
    logic signed [STEP_W+1:0]  disp;
    logic signed [COORD_W+1:0] sum;
    logic signed [COORD_W-1:0] prop_next;

    // counters
    logic [TOT_W-1:0]          total_reg;
    logic [CNT_W-1:0]          old_reg, new_reg;
    logic [ACC_W-1:0]          acc_reg;
    logic                      accept_ok;

    // pair pipeline ports
    logic                      iss_v_reg;
    logic [1:0]                iss_tag_reg;
    logic [ADDR_W-1:0]         iss_addr_reg;
    logic signed [COORD_W-1:0] pa_x, pa_y;
    logic                      po_valid, po_close, pipe_busy;
    logic [1:0]                po_tag;
    logic [ADDR_W-1:0]         po_addr;
    logic signed [COORD_W-1:0] po_wx, po_wy;

    rsp_t                      rsp_reg, rsp_next;

    // request latch
    always_ff @(posedge clk)
    begin
        if (cmd.take_req)
            req_reg <= req;
    end

    assign disc_ok = CNT_W'(req_reg.disc) < CNT_W'(MAX_DISCS);

    // write port selection
    always_comb
    begin
        we_x   = 1'b0;
        we_y   = 1'b0;
        waddr  = cmd.addr;
        wdat_x = '0;
        wdat_y = '0;
        priority if (cmd.clr_we)
        begin
            we_x = 1'b1;
            we_y = 1'b1;
        end
        else if (cmd.wr_coord)
        begin
            waddr  = req_reg.disc[ADDR_W-1:0];
            we_x   = disc_ok && !req_reg.axis;
            we_y   = disc_ok && req_reg.axis;
            wdat_x = req_reg.coord_in;
            wdat_y = req_reg.coord_in;
        end
        else if (cmd.decide && accept_ok)
        begin
            we_x   = !prop_axis_reg;
            we_y   = prop_axis_reg;
            wdat_x = prop_reg;
            wdat_y = prop_reg;
        end
        else if (po_valid && (po_tag == TAG_WRAP))
        begin
            waddr  = po_addr;
            we_x   = 1'b1;
            we_y   = 1'b1;
            wdat_x = po_wx;
            wdat_y = po_wy;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (we_x)
            mem_x[waddr] <= wdat_x;
        if (we_y)
            mem_y[waddr] <= wdat_y;
        if (cmd.rd_en)
        begin
            rd_x_reg <= mem_x[cmd.addr];
            rd_y_reg <= mem_y[cmd.addr];
        end
    end

    // reference disc
    always_ff @(posedge clk)
    begin
        if (cmd.latch_a)
        begin
            a_x_reg <= rd_x_reg;
            a_y_reg <= rd_y_reg;
        end
    end

    // lcg step: partial products, then sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcg_reg  <= LCG_RST;
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.draw;
            if (pend_reg)
                lcg_reg <= p_ll_reg + {p_hl_reg + p_lh_reg, 32'b0} + LCG_ADD;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.draw)
        begin
            p_ll_reg <= lcg_reg[31:0] * LCG_MUL[31:0];
            p_hl_reg <= 32'(lcg_reg[63:32] * LCG_MUL[31:0]);
            p_lh_reg <= 32'(lcg_reg[31:0] * LCG_MUL[63:32]);
        end
    end

    // proposal: step * u1 / 2^31 - step, saturated
    assign disp = $signed({1'b0, prod_reg[STEP_W+31:31]}) - $signed((STEP_W + 2)'(step_size));
    assign sum  = (COORD_W + 2)'(cmd.axis ? a_y_reg : a_x_reg) + (COORD_W + 2)'(disp);

    always_comb
    begin
        priority if (sum > $signed((COORD_W + 2)'({1'b0, {(COORD_W - 1){1'b1}}})))
            prop_next = {1'b0, {(COORD_W - 1){1'b1}}};
        else if (sum < -$signed((COORD_W + 2)'({1'b1, {(COORD_W - 1){1'b0}}})))
            prop_next = {1'b1, {(COORD_W - 1){1'b0}}};
        else
            prop_next = sum[COORD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_disp)
            prod_reg <= step_size * lcg_reg[63:32];
        if (cmd.calc_prop)
        begin
            prop_reg      <= prop_next;
            prop_axis_reg <= cmd.axis;
        end
        if (cmd.take_u2)
            u2_ok_reg <= (lcg_reg[63:32] != '1);
    end

    // pair issue, registered alongside the memory read so that it lines up with the read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iss_v_reg <= 1'b0;
        else
            iss_v_reg <= cmd.issue;
    end

    always_ff @(posedge clk)
    begin
        iss_tag_reg  <= cmd.tag;
        iss_addr_reg <= cmd.addr;
    end

    always_comb
    begin
        pa_x = a_x_reg;
        pa_y = a_y_reg;
        if (iss_tag_reg == TAG_WRAP)
        begin
            pa_x = '0;
            pa_y = '0;
        end
        else if (iss_tag_reg == TAG_NEW)
        begin
            if (prop_axis_reg)
                pa_y = prop_reg;
            else
                pa_x = prop_reg;
        end
    end

    hdms_pair_pipe u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (iss_v_reg),
        .in_tag     (iss_tag_reg),
        .in_addr    (iss_addr_reg),
        .ax         (pa_x),
        .ay         (pa_y),
        .bx         (rd_x_reg),
        .by         (rd_y_reg),
        .box_len    (box_length),
        .out_valid  (po_valid),
        .out_tag    (po_tag),
        .out_addr   (po_addr),
        .out_close  (po_close),
        .out_wrap_x (po_wx),
        .out_wrap_y (po_wy),
        .busy       (pipe_busy)
    );

    // acceptance test
    assign accept_ok = u2_ok_reg && (new_reg == '0) && (total_reg == TOT_W'(old_reg));

    // overlap and acceptance counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            old_reg   <= '0;
            new_reg   <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            if (cmd.clr_sweep)
            begin
                total_reg <= '0;
                acc_reg   <= '0;
            end
            else if (cmd.decide && accept_ok)
            begin
                total_reg <= '0;
                acc_reg   <= acc_reg + 1'b1;
            end
            else if (po_valid && po_close && (po_tag == TAG_TOTAL))
                total_reg <= total_reg + 1'b1;

            if (cmd.clr_cnt)
            begin
                old_reg <= '0;
                new_reg <= '0;
            end
            else if (po_valid && po_close)
            begin
                if (po_tag == TAG_OLD)
                    old_reg <= old_reg + 1'b1;
                if (po_tag == TAG_NEW)
                    new_reg <= new_reg + 1'b1;
            end
        end
    end

    // response selection
    always_comb
    begin
        rsp_next = '0;
        unique case (cmd.rsp_sel)
            RSP_COORD:
            begin
                if (disc_ok)
                    rsp_next.coord_out = req_reg.axis ? rd_y_reg : rd_x_reg;
            end
            RSP_SWEEP:
                rsp_next.accepted_moves = acc_reg;
            default:
                rsp_next = '0;
        endcase
    end

    // response register
    always_ff @(posedge clk)
    begin
        if (cmd.load_rsp)
            rsp_reg <= rsp_next;
    end

    assign rsp       = rsp_reg;
    assign stat.busy = pipe_busy || iss_v_reg;
    assign stat.cmd  = req_reg.cmd;
    assign stat.disc = req_reg.disc;

endmodule

### hw/rtl/hdms_ctrl.sv
// controller: clearing pass, command dispatch and sweep sequencing
// drives the datapath through dp_cmd_t; uses hdms_pkg
module hdms_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    input  logic [hdms_pkg::CNT_W-1:0]  n_discs,
    input  hdms_pkg::dp_stat_t          stat,
    output hdms_pkg::dp_cmd_t           cmd
);
    import hdms_pkg::*;

    localparam logic [4:0] S_CLEAR   = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_EXEC    = 5'd2;
    localparam logic [4:0] S_T_RD    = 5'd3;
    localparam logic [4:0] S_T_LATCH = 5'd4;
    localparam logic [4:0] S_T_ISS   = 5'd5;
    localparam logic [4:0] S_C_RD    = 5'd6;
    localparam logic [4:0] S_C_LATCH = 5'd7;
    localparam logic [4:0] S_C_W1    = 5'd8;
    localparam logic [4:0] S_C_MUL   = 5'd9;
    localparam logic [4:0] S_C_PROP  = 5'd10;
    localparam logic [4:0] S_C_U2    = 5'd11;
    localparam logic [4:0] S_C_OLD   = 5'd12;
    localparam logic [4:0] S_C_NEW   = 5'd13;
    localparam logic [4:0] S_C_WAIT  = 5'd14;
    localparam logic [4:0] S_C_DEC   = 5'd15;
    localparam logic [4:0] S_W_ISS   = 5'd16;
    localparam logic [4:0] S_W_WAIT  = 5'd17;
    localparam logic [4:0] S_DONE    = 5'd18;

    logic [4:0]       state_reg, state_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W:0]   c_reg, c_next;
    logic [1:0]       sel_reg, sel_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [CNT_W-1:0] d;

    assign d = c_reg[CNT_W:1];

    // next state and commands
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        c_next         = c_reg;
        sel_next       = sel_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd.axis       = c_reg[0];
        cmd.rsp_sel    = sel_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_we = 1'b1;
                cmd.addr   = i_reg[ADDR_W-1:0];
                i_next     = i_reg + 1'b1;
                if (i_reg == CNT_W'(MAX_DISCS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.take_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                priority if (stat.cmd == CMD_WRITE)
                begin
                    cmd.wr_coord = 1'b1;
                    sel_next     = RSP_ZERO;
                    state_next   = S_DONE;
                end
                else if (stat.cmd == CMD_READ)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.addr   = stat.disc[ADDR_W-1:0];
                    sel_next   = RSP_COORD;
                    state_next = S_DONE;
                end
                else if (stat.cmd == CMD_SWEEP)
                begin
                    cmd.clr_sweep = 1'b1;
                    i_next        = '0;
                    state_next    = S_T_RD;
                end
                else
                begin
                    sel_next   = RSP_ZERO;
                    state_next = S_DONE;
                end
            end
            // overlap count over all pairs before the first move
            S_T_RD:
            begin
                if (i_reg == n_discs)
                begin
                    c_next     = '0;
                    state_next = S_C_RD;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.addr   = i_reg[ADDR_W-1:0];
                    state_next = S_T_LATCH;
                end
            end
            S_T_LATCH:
            begin
                cmd.latch_a = 1'b1;
                j_next      = '0;
                state_next  = S_T_ISS;
            end
            S_T_ISS:
            begin
                if (j_reg == i_reg)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_T_RD;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    cmd.addr  = j_reg[ADDR_W-1:0];
                    cmd.issue = 1'b1;
                    cmd.tag   = TAG_TOTAL;
                    j_next    = j_reg + 1'b1;
                end
            end
            // one coordinate move
            S_C_RD:
            begin
                if (c_reg == {n_discs, 1'b0})
                begin
                    j_next     = '0;
                    state_next = S_W_ISS;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.addr   = d[ADDR_W-1:0];
                    state_next = S_C_LATCH;
                end
            end
            S_C_LATCH:
            begin
                cmd.latch_a = 1'b1;
                cmd.draw    = 1'b1;
                state_next  = S_C_W1;
            end
            S_C_W1:
                state_next = S_C_MUL;
            S_C_MUL:
            begin
                cmd.mul_disp = 1'b1;
                cmd.draw     = 1'b1;
                state_next   = S_C_PROP;
            end
            S_C_PROP:
            begin
                cmd.calc_prop = 1'b1;
                state_next    = S_C_U2;
            end
            S_C_U2:
            begin
                cmd.take_u2 = 1'b1;
                cmd.clr_cnt = 1'b1;
                j_next      = '0;
                state_next  = S_C_OLD;
            end
            S_C_OLD:
            begin
                if (j_reg == n_discs)
                begin
                    j_next     = '0;
                    state_next = S_C_NEW;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    cmd.addr  = j_reg[ADDR_W-1:0];
                    cmd.issue = (j_reg != d);
                    cmd.tag   = TAG_OLD;
                    j_next    = j_reg + 1'b1;
                end
            end
            S_C_NEW:
            begin
                if (j_reg == n_discs)
                    state_next = S_C_WAIT;
                else
                begin
                    cmd.rd_en = 1'b1;
                    cmd.addr  = j_reg[ADDR_W-1:0];
                    cmd.issue = (j_reg != d);
                    cmd.tag   = TAG_NEW;
                    j_next    = j_reg + 1'b1;
                end
            end
            S_C_WAIT:
            begin
                if (!stat.busy)
                    state_next = S_C_DEC;
            end
            S_C_DEC:
            begin
                cmd.decide = 1'b1;
                cmd.addr   = d[ADDR_W-1:0];
                c_next     = c_reg + 1'b1;
                state_next = S_C_RD;
            end
            // rewrap pass
            S_W_ISS:
            begin
                if (j_reg == n_discs)
                    state_next = S_W_WAIT;
                else
                begin
                    cmd.rd_en = 1'b1;
                    cmd.addr  = j_reg[ADDR_W-1:0];
                    cmd.issue = 1'b1;
                    cmd.tag   = TAG_WRAP;
                    j_next    = j_reg + 1'b1;
                end
            end
            S_W_WAIT:
            begin
                if (!stat.busy)
                begin
                    sel_next   = RSP_SWEEP;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.load_rsp   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            i_reg         <= '0;
            j_reg         <= '0;
            c_reg         <= '0;
            sel_reg       <= RSP_ZERO;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            c_reg         <= c_next;
            sel_reg       <= sel_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

### hw/rtl/hard_disk_metropolis_sweep_unit.sv
// hard-disc metropolis sweep unit: top level with configuration registers
// a sweep of n discs is paced by the one-pair-per-cycle overlap pipeline and waits for
// that pipeline to drain after every move; one transaction is worked on at a time
// after reset a clearing pass zeroes all 512 disc rows before the first transaction is
// taken; configuration writes are taken at any time
module hard_disk_metropolis_sweep_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  hdms_pkg::req_t                  req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output hdms_pkg::rsp_t                  rsp,
    input  logic                            cfg_we,
    input  logic [hdms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hdms_pkg::CFG_W-1:0]      cfg_data
);
    import hdms_pkg::*;

    logic [LEN_W-1:0]  box_length_reg;
    logic [STEP_W-1:0] step_size_reg;
    logic [ACT_W-1:0]  active_discs_reg;
    logic [CNT_W-1:0]  n_discs;
    dp_cmd_t           cmd;
    dp_stat_t          stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_length_reg   <= BOX_LENGTH_RST;
            step_size_reg    <= STEP_SIZE_RST;
            active_discs_reg <= ACTIVE_DISCS_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_BOX_LENGTH)
                box_length_reg <= cfg_data[LEN_W-1:0];
            if (cfg_index == CFG_STEP_SIZE)
                step_size_reg <= cfg_data[STEP_W-1:0];
            if (cfg_index == CFG_ACTIVE_DISCS)
                active_discs_reg <= cfg_data[ACT_W-1:0];
        end
    end

    // disc count limited to storage
    assign n_discs = (CNT_W'(active_discs_reg) > CNT_W'(MAX_DISCS)) ?
                     CNT_W'(MAX_DISCS) : CNT_W'(active_discs_reg);

    hdms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .n_discs   (n_discs),
        .stat      (stat),
        .cmd       (cmd)
    );

    hdms_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .box_length (box_length_reg),
        .step_size  (step_size_reg),
        .cmd        (cmd),
        .stat       (stat),
        .rsp        (rsp)
    );

endmodule
